>>> hw/rtl/olist_pkg.sv
// ----------------------------------------------------------------------------
// Ordered list package
// Shared constants, operation codes and the command/status bundles that join
// the controller and the datapath of the ordered list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package olist_pkg;

  // Store geometry.
  localparam int DEPTH  = 64;
  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int POS_W  = 7;
  localparam int WORD_W = 32;

  // Operation codes carried by the mode field of an item.
  typedef enum logic [2:0] {
    MODE_APPEND   = 3'd0,
    MODE_INSERT   = 3'd1,
    MODE_SET      = 3'd2,
    MODE_REMOVE   = 3'd3,
    MODE_GET      = 3'd4,
    MODE_INDEX_OF = 3'd5,
    MODE_CONTAINS = 3'd6,
    MODE_CLEAR    = 3'd7
  } mode_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic op_load;
    logic idx_zero;
    logic idx_count;
    logic idx_pos;
    logic shup_step;
    logic shdn_step;
    logic scan_step;
    logic flush;
    logic put;
    logic set_wr;
    logic read_pos;
    logic cap;
    logic cnt_dec;
    logic cnt_clr;
    logic set_ok;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    mode_t mode;
    logic  pos_lt_cnt;
    logic  pos_le_cnt;
    logic  full;
    logic  shup_end;
    logic  shdn_end;
    logic  scan_hit;
    logic  scan_end;
  } status_t;

endpackage

`default_nettype wire

>>> hw/rtl/ordered_list_insert_remove_engine.sv
// Insert and remove shift the entries behind the position; index_of and contains
// search from the front of the list until a match or the end of the list.
// One item is in work at a time; the next is taken the cycle after its result
// is loaded. Shifts and searches move one entry per cycle through the memory.
// Synchronous reset empties the list; entry contents are not cleared.
// ----------------------------------------------------------------------------
// Ordered list engine top level
// Ties the sequencing controller to the entry datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_list_insert_remove_engine
  import olist_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [2:0]               mode,
  input  wire logic [POS_W-1:0]         position,
  input  wire logic signed [WORD_W-1:0] value,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic                          ok,
  output logic signed [WORD_W-1:0]      data,
  output logic [CW-1:0]                 count,
  output logic                          empty_res
);

  cmd_t    cmd;
  status_t sts;

  // Operation sequencer.
  olist_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Entry store and result path.
  olist_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .mode      (mode),
    .position  (position),
    .value     (value),
    .ok        (ok),
    .data      (data),
    .count     (count),
    .empty_res (empty_res)
  );

endmodule

`default_nettype wire

>>> hw/rtl/olist_ctrl.sv
// ----------------------------------------------------------------------------
// Ordered list controller
// One-hot state machine that sequences each operation over the datapath and
// owns the handshakes of both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module olist_ctrl
  import olist_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  wire logic    out_stall,
  input  wire status_t sts,
  output cmd_t         cmd
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_DEC  = 9'b000000010,
    S_PUT  = 9'b000000100,
    S_SHUP = 9'b000001000,
    S_READ = 9'b000010000,
    S_CAP  = 9'b000100000,
    S_SHDN = 9'b001000000,
    S_SCAN = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  // A new item is taken only between operations.
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op_load = 1'b1;
          state_next  = S_DEC;
        end
      end
      S_DEC: begin
        state_next = S_DONE;
        case (sts.mode)
          MODE_APPEND: begin
            if (!sts.full) begin
              cmd.idx_count = 1'b1;
              state_next    = S_PUT;
            end
          end
          MODE_INSERT: begin
            if (!sts.full && sts.pos_le_cnt) begin
              cmd.idx_count = 1'b1;
              state_next    = S_SHUP;
            end
          end
          MODE_SET: begin
            if (sts.pos_lt_cnt) begin
              cmd.set_wr = 1'b1;
            end
          end
          MODE_REMOVE, MODE_GET: begin
            if (sts.pos_lt_cnt) begin
              state_next = S_READ;
            end
          end
          MODE_INDEX_OF, MODE_CONTAINS: begin
            cmd.idx_zero = 1'b1;
            state_next   = S_SCAN;
          end
          default: begin
            cmd.cnt_clr = 1'b1;
            cmd.set_ok  = 1'b1;
          end
        endcase
      end
      S_PUT: begin
        cmd.put    = 1'b1;
        state_next = S_DONE;
      end
      S_SHUP: begin
        if (sts.shup_end) begin
          cmd.flush  = 1'b1;
          state_next = S_PUT;
        end else begin
          cmd.shup_step = 1'b1;
        end
      end
      S_READ: begin
        cmd.read_pos = 1'b1;
        state_next   = S_CAP;
      end
      S_CAP: begin
        cmd.cap = 1'b1;
        if (sts.mode == MODE_REMOVE) begin
          cmd.idx_pos = 1'b1;
          state_next  = S_SHDN;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SHDN: begin
        if (sts.shdn_end) begin
          cmd.flush   = 1'b1;
          cmd.cnt_dec = 1'b1;
          state_next  = S_DONE;
        end else begin
          cmd.shdn_step = 1'b1;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_hit || sts.scan_end) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and result-valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/olist_dp.sv
// ----------------------------------------------------------------------------
// Ordered list datapath
// Entry memory with one write and one registered read port, the entry count,
// the walking index with its pending move, and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module olist_dp
  import olist_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire cmd_t                     cmd,
  output status_t                       sts,
  input  wire logic [2:0]               mode,
  input  wire logic [POS_W-1:0]         position,
  input  wire logic signed [WORD_W-1:0] value,
  output logic                          ok,
  output logic signed [WORD_W-1:0]      data,
  output logic [CW-1:0]                 count,
  output logic                          empty_res
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_q;

  mode_t             mode_r;
  logic [POS_W-1:0]  pos_r;
  logic [WORD_W-1:0] value_r;
  logic [CW-1:0]     entry_count;
  logic [CW-1:0]     idx;
  logic [CW-1:0]     idx_inc;
  logic [CW-1:0]     idx_dec;
  logic              pend;
  logic [AW-1:0]     pend_addr;
  logic              res_ok;
  logic [WORD_W-1:0] res_data;

  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic              scan_rd;

  assign idx_inc = idx + CW'(1);
  assign idx_dec = idx - CW'(1);
  assign scan_rd = cmd.scan_step && (idx < entry_count);

  // Status toward the controller.
  always_comb begin
    sts.mode       = mode_r;
    sts.pos_lt_cnt = (pos_r < entry_count);
    sts.pos_le_cnt = (pos_r <= entry_count);
    sts.full       = (entry_count == CW'(DEPTH));
    sts.shup_end   = (idx == pos_r);
    sts.shdn_end   = (idx_inc >= entry_count);
    sts.scan_hit   = pend && (rd_q == value_r);
    sts.scan_end   = (idx >= entry_count) && !pend;
  end

  // Read port address selection.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = pos_r[AW-1:0];
    if (cmd.read_pos) begin
      rd_en = 1'b1;
    end else if (cmd.shup_step) begin
      rd_en   = 1'b1;
      rd_addr = idx_dec[AW-1:0];
    end else if (cmd.shdn_step) begin
      rd_en   = 1'b1;
      rd_addr = idx_inc[AW-1:0];
    end else if (scan_rd) begin
      rd_en   = 1'b1;
      rd_addr = idx[AW-1:0];
    end
  end

  // Write port selection: a new word, or the pending move of a shift.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pend_addr;
    wr_data = rd_q;
    if (cmd.set_wr) begin
      wr_en   = 1'b1;
      wr_addr = pos_r[AW-1:0];
      wr_data = value_r;
    end else if (cmd.put) begin
      wr_en   = 1'b1;
      wr_addr = idx[AW-1:0];
      wr_data = value_r;
    end else if ((cmd.shup_step || cmd.shdn_step || cmd.flush) && pend) begin
      wr_en = 1'b1;
    end
  end

  // Entry memory.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Entry count and pending-move flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      pend        <= 1'b0;
    end else begin
      if (cmd.cnt_clr) begin
        entry_count <= '0;
      end else if (cmd.put) begin
        entry_count <= entry_count + CW'(1);
      end else if (cmd.cnt_dec) begin
        entry_count <= entry_count - CW'(1);
      end
      if (cmd.op_load || cmd.flush) begin
        pend <= 1'b0;
      end else if (cmd.shup_step || cmd.shdn_step) begin
        pend <= 1'b1;
      end else if (cmd.scan_step) begin
        pend <= scan_rd;
      end
    end
  end

  // Operand, index and result registers.
  always_ff @(posedge clk) begin
    if (cmd.op_load) begin
      mode_r   <= mode_t'(mode);
      pos_r    <= position;
      value_r  <= value;
      res_ok   <= 1'b0;
      res_data <= '0;
    end
    if (cmd.idx_zero) begin
      idx <= '0;
    end else if (cmd.idx_count) begin
      idx <= entry_count;
    end else if (cmd.idx_pos) begin
      idx <= CW'(pos_r);
    end else if (cmd.shup_step) begin
      idx       <= idx_dec;
      pend_addr <= idx[AW-1:0];
    end else if (cmd.shdn_step) begin
      idx       <= idx_inc;
      pend_addr <= idx[AW-1:0];
    end else if (scan_rd) begin
      idx       <= idx_inc;
      pend_addr <= idx[AW-1:0];
    end
    if (cmd.set_wr || cmd.put || cmd.set_ok) begin
      res_ok <= 1'b1;
    end
    if (cmd.cap) begin
      res_ok   <= 1'b1;
      res_data <= rd_q;
    end
    if (cmd.scan_step && sts.scan_hit) begin
      res_ok <= 1'b1;
      if (mode_r == MODE_INDEX_OF) begin
        res_data <= {{(WORD_W-AW){1'b0}}, pend_addr};
      end
    end
  end

  // Output register of the result channel.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      ok        <= res_ok;
      data      <= res_data;
      count     <= entry_count;
      empty_res <= (entry_count == '0);
    end
  end

endmodule

`default_nettype wire

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// Ordered list engine testbench
// Drives list operations through the input channel and keeps its own copy of
// the list, which predicts the ok, data, count and empty fields of every
// result. A short table of directed items comes first. Random epochs of
// growing and shrinking lists follow, under several idling and stalling
// patterns on both channels.
// ----------------------------------------------------------------------------

module tb
  import olist_pkg::*;
();

  // One result item as the block reports it.
  typedef struct packed {
    logic                     ok;
    logic signed [WORD_W-1:0] data;
    logic [CW-1:0]            count;
    logic                     empty_res;
  } list_result_t;

  // One row of the directed table. Rows with typed set carry their result.
  typedef struct packed {
    mode_t                    op;
    logic [POS_W-1:0]         pos;
    logic signed [WORD_W-1:0] word;
    logic                     typed;
    list_result_t             res;
  } dir_row_t;

  localparam int           STALL_LIMIT = 5000;
  localparam int           PHASE_ITEMS = 400;
  localparam list_result_t NO_RES      = '0;
  localparam list_result_t EMPTY_FAIL  = '{1'b0, 32'sh0, 7'd0, 1'b1};
  localparam list_result_t EMPTY_DONE  = '{1'b1, 32'sh0, 7'd0, 1'b1};

  localparam dir_row_t DIR_TABLE [25] = '{
    // Every access to the empty list fails.
    '{MODE_GET,      7'd0,  32'sh0,        1'b1, EMPTY_FAIL},
    '{MODE_REMOVE,   7'd0,  32'sh0,        1'b1, EMPTY_FAIL},
    '{MODE_INDEX_OF, 7'd0,  32'sh0,        1'b1, EMPTY_FAIL},
    '{MODE_CONTAINS, 7'd0,  32'shFFFFFFFF, 1'b1, EMPTY_FAIL},
    '{MODE_INSERT,   7'd1,  32'sh5,        1'b1, EMPTY_FAIL},
    '{MODE_SET,      7'd0,  32'sh5,        1'b1, EMPTY_FAIL},
    // Build a list from the extreme words.
    '{MODE_APPEND,   7'd0,  32'sh7FFFFFFF, 1'b1, '{1'b1, 32'sh0, 7'd1, 1'b0}},
    '{MODE_APPEND,   7'd0,  32'sh80000000, 1'b1, '{1'b1, 32'sh0, 7'd2, 1'b0}},
    '{MODE_INSERT,   7'd0,  32'shFFFFFFFF, 1'b1, '{1'b1, 32'sh0, 7'd3, 1'b0}},
    '{MODE_INSERT,   7'd3,  32'sh0,        1'b1, '{1'b1, 32'sh0, 7'd4, 1'b0}},
    '{MODE_INSERT,   7'd5,  32'sh1,        1'b1, '{1'b0, 32'sh0, 7'd4, 1'b0}},
    '{MODE_SET,      7'd1,  32'sh55555555, 1'b0, NO_RES},
    '{MODE_SET,      7'd4,  32'sh1,        1'b1, '{1'b0, 32'sh0, 7'd4, 1'b0}},
    '{MODE_GET,      7'd0,  32'sh0,        1'b0, NO_RES},
    '{MODE_GET,      7'd3,  32'sh0,        1'b0, NO_RES},
    '{MODE_GET,      7'd64, 32'sh0,        1'b1, '{1'b0, 32'sh0, 7'd4, 1'b0}},
    // Searches with and without a match, then removes, an append and clears.
    '{MODE_INDEX_OF, 7'd0,  32'sh80000000, 1'b0, NO_RES},
    '{MODE_CONTAINS, 7'd0,  32'sh0,        1'b0, NO_RES},
    '{MODE_INDEX_OF, 7'd0,  32'sh3039,     1'b0, NO_RES},
    '{MODE_REMOVE,   7'd1,  32'sh0,        1'b0, NO_RES},
    '{MODE_REMOVE,   7'd3,  32'sh0,        1'b1, '{1'b0, 32'sh0, 7'd3, 1'b0}},
    '{MODE_APPEND,   7'd64, 32'shAAAAAAAA, 1'b0, NO_RES},
    '{MODE_CLEAR,    7'd0,  32'sh0,        1'b1, EMPTY_DONE},
    '{MODE_CLEAR,    7'd9,  32'sh1234,     1'b1, EMPTY_DONE},
    '{MODE_GET,      7'd0,  32'sh0,        1'b1, EMPTY_FAIL}
  };

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [2:0]               mode = 3'd0;
  logic [POS_W-1:0]         position = '0;
  logic signed [WORD_W-1:0] value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     ok;
  logic signed [WORD_W-1:0] data;
  logic [CW-1:0]            count;
  logic                     empty_res;

  // Shadow copy of the list and the results still owed by the block.
  logic signed [WORD_W-1:0] list_words [DEPTH];
  int                       list_len = 0;
  list_result_t             pending_results [$];
  list_result_t             oldest;
  int                       mismatch_count = 0;
  int                       quiet_cycles = 0;
  int                       send_idle_pct = 0;
  int                       recv_stall_pct = 0;

  ordered_list_insert_remove_engine i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .position  (position),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ok        (ok),
    .data      (data),
    .count     (count),
    .empty_res (empty_res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one operation to the shadow list and returns the result it owes.
  function automatic list_result_t apply_list_op(input mode_t op,
                                                 input logic [POS_W-1:0] pos,
                                                 input logic signed [WORD_W-1:0] word);
    list_result_t r;
    int           at;
    int           i;
    r  = '0;
    at = (op == MODE_APPEND) ? list_len : int'(pos);
    case (op)
      MODE_APPEND, MODE_INSERT: begin
        if (at <= list_len && list_len < DEPTH) begin
          for (i = list_len; i > at; i--) list_words[i] = list_words[i - 1];
          list_words[at] = word;
          list_len++;
          r.ok = 1'b1;
        end
      end
      MODE_SET: begin
        if (at < list_len) begin
          list_words[at] = word;
          r.ok = 1'b1;
        end
      end
      MODE_REMOVE: begin
        if (at < list_len) begin
          r.data = list_words[at];
          for (i = at; i + 1 < list_len; i++) list_words[i] = list_words[i + 1];
          list_len--;
          r.ok = 1'b1;
        end
      end
      MODE_GET: begin
        if (at < list_len) begin
          r.data = list_words[at];
          r.ok = 1'b1;
        end
      end
      MODE_INDEX_OF, MODE_CONTAINS: begin
        // The first matching position wins.
        for (i = 0; i < list_len && !r.ok; i++) begin
          if (list_words[i] == word) begin
            r.ok = 1'b1;
            if (op == MODE_INDEX_OF) r.data = i;
          end
        end
      end
      default: begin
        list_len = 0;
        r.ok = 1'b1;
      end
    endcase
    r.count     = CW'(list_len);
    r.empty_res = (list_len == 0);
    return r;
  endfunction

  // Offers one item, waits for it to be taken, then records what it owes.
  task automatic send_op(input mode_t op, input logic [POS_W-1:0] pos,
                         input logic signed [WORD_W-1:0] word,
                         input logic typed, input list_result_t typed_res);
    list_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= op;
    position <= pos;
    value    <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = apply_list_op(op, pos, word);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  // Picks an operation; a growing list favors inserts, a shrinking one removes.
  function automatic mode_t pick_mode(input bit growing);
    int roll;
    roll = $urandom_range(99);
    if (roll == 0) return MODE_CLEAR;
    if (growing) begin
      if (roll < 31) return MODE_APPEND;
      if (roll < 56) return MODE_INSERT;
      if (roll < 64) return MODE_SET;
      if (roll < 74) return MODE_REMOVE;
      if (roll < 84) return MODE_GET;
      if (roll < 92) return MODE_INDEX_OF;
      return MODE_CONTAINS;
    end
    if (roll < 11) return MODE_APPEND;
    if (roll < 19) return MODE_INSERT;
    if (roll < 27) return MODE_SET;
    if (roll < 72) return MODE_REMOVE;
    if (roll < 82) return MODE_GET;
    if (roll < 91) return MODE_INDEX_OF;
    return MODE_CONTAINS;
  endfunction

  // Words come from a small pool, from the list itself, or from anywhere,
  // so that searches both hit and miss.
  function automatic logic signed [WORD_W-1:0] pick_word();
    int roll;
    roll = $urandom_range(99);
    if (roll < 35) begin
      case ($urandom_range(4))
        0: return 32'sh0;
        1: return 32'shFFFFFFFF;
        2: return 32'sh7FFFFFFF;
        3: return 32'sh80000000;
        default: return $urandom_range(15);
      endcase
    end
    if (roll < 65 && list_len > 0) return list_words[$urandom_range(list_len - 1)];
    return $urandom;
  endfunction

  function automatic void check_field(input string name, input logic [WORD_W-1:0] want_v,
                                      input logic [WORD_W-1:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
      mismatch_count++;
    end
  endfunction

  // Result side: compare each taken result, then choose the next stall.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual ok=%b data=%h count=%0d",
                   $time, ok, data, count);
          mismatch_count++;
        end else begin
          oldest = pending_results.pop_front();
          check_field("ok", WORD_W'(oldest.ok), WORD_W'(ok));
          check_field("data", oldest.data, data);
          check_field("count", WORD_W'(oldest.count), WORD_W'(count));
          check_field("empty_res", WORD_W'(oldest.empty_res), WORD_W'(empty_res));
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: too long without any item taken on either side ends the run.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus: directed table, then random epochs under each idling pattern.
  initial begin
    int               ph;
    int               n;
    int               epoch_left;
    bit               growing;
    mode_t            op;
    logic [POS_W-1:0] pos;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (DIR_TABLE[k]) begin
      send_op(DIR_TABLE[k].op, DIR_TABLE[k].pos, DIR_TABLE[k].word,
              DIR_TABLE[k].typed, DIR_TABLE[k].res);
    end

    growing    = 1'b1;
    epoch_left = $urandom_range(60, 140);
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (epoch_left == 0) begin
          growing    = !growing;
          epoch_left = $urandom_range(40, 140);
        end
        epoch_left--;
        op = pick_mode(growing);
        // Mostly positions near the list; sometimes anywhere from 0 to DEPTH.
        if ($urandom_range(99) < 15) pos = POS_W'($urandom_range(DEPTH));
        else pos = POS_W'($urandom_range(list_len));
        send_op(op, pos, pick_word(), 1'b0, NO_RES);
      end
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
